>>> src/thermistor_code_to_temperature_defines.svh
// Assertion macros shared by the thermistor conversion modules.
// Each use samples on clk and is disabled while rst is high.
`ifndef THERMISTOR_CODE_TO_TEMPERATURE_DEFINES_SVH
`define THERMISTOR_CODE_TO_TEMPERATURE_DEFINES_SVH

// Same-cycle implication.
`define TCTT_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define TCTT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/tctt_pkg.sv
package tctt_pkg;

  localparam logic [5:0]         FirstIdx   = 6'd1;
  localparam logic [5:0]         LastIdx    = 6'd42;
  localparam logic [11:0]        CodeTop    = 12'd4063;
  localparam logic [11:0]        CodeBottom = 12'd216;
  localparam logic [11:0]        PortLow    = 12'd3990;
  localparam logic [11:0]        PortHigh   = 12'd4010;
  localparam logic signed [14:0] TempLow    = -15'sd5500;
  localparam logic signed [14:0] TempHigh   = 15'sd15500;
  localparam logic signed [14:0] TempStep   = 15'sd500;
  localparam logic [3:0]         QuoLast    = 4'd8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_LOAD,
    ST_DIV,
    ST_HOLD
  } state_t;

  // Segment found by the table walk: upper and lower end codes, base temperature.
  typedef struct packed {
    logic [11:0]        hi;
    logic [11:0]        lo;
    logic signed [14:0] base;
  } seg_t;

  // Converter code at each 5 degree point, from -55 C upwards.
  function automatic logic [11:0] code_at(input logic [5:0] idx);
    logic [11:0] c;
    unique case (idx)
      6'd0:  c = 12'd4063;
      6'd1:  c = 12'd4051;
      6'd2:  c = 12'd4035;
      6'd3:  c = 12'd4015;
      6'd4:  c = 12'd3988;
      6'd5:  c = 12'd3955;
      6'd6:  c = 12'd3913;
      6'd7:  c = 12'd3861;
      6'd8:  c = 12'd3798;
      6'd9:  c = 12'd3722;
      6'd10: c = 12'd3633;
      6'd11: c = 12'd3530;
      6'd12: c = 12'd3411;
      6'd13: c = 12'd3279;
      6'd14: c = 12'd3132;
      6'd15: c = 12'd2973;
      6'd16: c = 12'd2805;
      6'd17: c = 12'd2629;
      6'd18: c = 12'd2448;
      6'd19: c = 12'd2266;
      6'd20: c = 12'd2086;
      6'd21: c = 12'd1910;
      6'd22: c = 12'd1742;
      6'd23: c = 12'd1581;
      6'd24: c = 12'd1430;
      6'd25: c = 12'd1290;
      6'd26: c = 12'd1161;
      6'd27: c = 12'd1043;
      6'd28: c = 12'd936;
      6'd29: c = 12'd839;
      6'd30: c = 12'd753;
      6'd31: c = 12'd675;
      6'd32: c = 12'd606;
      6'd33: c = 12'd544;
      6'd34: c = 12'd489;
      6'd35: c = 12'd439;
      6'd36: c = 12'd395;
      6'd37: c = 12'd356;
      6'd38: c = 12'd322;
      6'd39: c = 12'd291;
      6'd40: c = 12'd263;
      6'd41: c = 12'd238;
      6'd42: c = 12'd216;
      default: c = 12'd0;
    endcase
    return c;
  endfunction

endpackage

>>> src/tctt_seg.sv
module tctt_seg (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [11:0]        code,
  output logic               done,
  output tctt_pkg::seg_t     seg
);

  logic                busy;
  logic [5:0]          idx;
  logic signed [14:0]  base;
  logic [11:0]         lo_code;
  logic                hit;

  assign lo_code = tctt_pkg::code_at(idx);
  assign hit     = (lo_code <= code) || (idx == tctt_pkg::LastIdx);
  assign done    = busy && hit;

  assign seg.hi   = tctt_pkg::code_at(idx - 6'd1);
  assign seg.lo   = lo_code;
  assign seg.base = base;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (done) begin
      busy <= 1'b0;
    end
  end

  // Advance one table point a cycle until the code is reached.
  always_ff @(posedge clk) begin
    if (start) begin
      idx  <= tctt_pkg::FirstIdx;
      base <= tctt_pkg::TempLow;
    end else if (busy && !hit) begin
      idx  <= idx + 6'd1;
      base <= base + tctt_pkg::TempStep;
    end
  end

endmodule

>>> src/tctt_div.sv
`include "thermistor_code_to_temperature_defines.svh"

module tctt_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [16:0] num,
  input  logic [7:0]  den,
  output logic        done,
  output logic [8:0]  quo
);

  logic       busy;
  logic [3:0] cnt;
  logic [7:0] rem;
  logic [8:0] low;
  logic [7:0] den_r;
  logic [8:0] trial;
  logic [8:0] trial_sub;
  logic       ge;
  logic [7:0] rem_next;

  // Quotient fits nine bits, so the top eight dividend bits already sit below den.
  assign trial     = {rem, low[8]};
  assign ge        = trial >= {1'b0, den_r};
  assign trial_sub = trial - {1'b0, den_r};
  assign rem_next  = ge ? trial_sub[7:0] : trial[7:0];
  assign done      = busy && (cnt == tctt_pkg::QuoLast);
  assign quo       = {low[7:0], ge};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (done) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= num[16:9];
      low   <= num[8:0];
      den_r <= den;
      cnt   <= 4'd0;
    end else if (busy) begin
      rem <= rem_next;
      low <= {low[7:0], ge};
      cnt <= cnt + 4'd1;
    end
  end

  `TCTT_ASSERT(rem_below_den, busy, rem < den_r, "partial remainder reached divisor")

endmodule

>>> src/thermistor_code_to_temperature.sv
// Thermistor code to temperature: one transfer of adc_code and port_level gives
// one transfer of temp_centi (hundredths of a degree C, truncated), the two range
// flags and sensor_on. Codes at or above 4063 clamp to -55 C with below_range,
// codes below 216 clamp to +155 C with above_range; both skip the walk and the
// divide. Other codes walk the 43-point table one point a cycle and then run a
// 9-step restoring divide. One item is in flight at a time; the result sits in an
// output register, so a new item is taken while the previous result awaits its
// transfer.
`include "thermistor_code_to_temperature_defines.svh"

module thermistor_code_to_temperature (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [11:0]        adc_code,
  input  logic [11:0]        port_level,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [14:0] temp_centi,
  output logic               below_range,
  output logic               above_range,
  output logic               sensor_on
);

  tctt_pkg::state_t   state;
  tctt_pkg::state_t   state_next;

  // Item held while the conversion runs
  logic [11:0]        code_r;
  logic               sensor_r;
  logic signed [14:0] res_temp;
  logic               res_below;
  logic               res_above;

  // Segment taken from the table walk
  logic [7:0]         diff_r;
  logic [7:0]         span_r;
  logic signed [14:0] base_r;

  logic               in_xfer;
  logic               clamp;
  logic               seg_start;
  logic               seg_done;
  tctt_pkg::seg_t     seg;
  logic               div_start;
  logic               div_done;
  logic [8:0]         quo;
  logic [16:0]        num;
  logic [11:0]        hi_minus_code;
  logic [11:0]        hi_minus_lo;
  logic               out_load;

  assign in_xfer = in_valid && in_ready;
  assign clamp   = (adc_code >= tctt_pkg::CodeTop) || (adc_code < tctt_pkg::CodeBottom);

  // 500 * diff as 512 - 8 - 4 times diff
  assign num = {diff_r, 9'd0} - {6'd0, diff_r, 3'd0} - {7'd0, diff_r, 2'd0};

  assign hi_minus_code = seg.hi - code_r;
  assign hi_minus_lo   = seg.hi - seg.lo;

  tctt_seg u_seg (
    .clk   (clk),
    .rst   (rst),
    .start (seg_start),
    .code  (code_r),
    .done  (seg_done),
    .seg   (seg)
  );

  tctt_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num),
    .den   (span_r),
    .done  (div_done),
    .quo   (quo)
  );

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      tctt_pkg::ST_IDLE: begin
        if (in_xfer) begin
          state_next = clamp ? tctt_pkg::ST_HOLD : tctt_pkg::ST_WALK;
        end
      end
      tctt_pkg::ST_WALK: begin
        if (seg_done) begin
          state_next = tctt_pkg::ST_LOAD;
        end
      end
      tctt_pkg::ST_LOAD: begin
        state_next = tctt_pkg::ST_DIV;
      end
      tctt_pkg::ST_DIV: begin
        if (div_done) begin
          state_next = tctt_pkg::ST_HOLD;
        end
      end
      tctt_pkg::ST_HOLD: begin
        if (out_load) begin
          state_next = tctt_pkg::ST_IDLE;
        end
      end
      default: state_next = tctt_pkg::ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    in_ready  = 1'b0;
    seg_start = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state)
      tctt_pkg::ST_IDLE: begin
        in_ready  = 1'b1;
        seg_start = in_valid && !clamp;
      end
      tctt_pkg::ST_LOAD: begin
        div_start = 1'b1;
      end
      tctt_pkg::ST_HOLD: begin
        out_load = !out_valid || out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tctt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Capture the item; clamped codes have their result settled here
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      code_r    <= adc_code;
      sensor_r  <= (port_level > tctt_pkg::PortLow) && (port_level < tctt_pkg::PortHigh);
      res_below <= adc_code >= tctt_pkg::CodeTop;
      res_above <= adc_code < tctt_pkg::CodeBottom;
      res_temp  <= (adc_code >= tctt_pkg::CodeTop) ? tctt_pkg::TempLow : tctt_pkg::TempHigh;
    end else if (div_done) begin
      res_temp <= base_r + $signed({6'd0, quo});
    end
  end

  // Hold the segment; diff and span both stay under 183 within one segment
  always_ff @(posedge clk) begin
    if (seg_done) begin
      diff_r <= hi_minus_code[7:0];
      span_r <= hi_minus_lo[7:0];
      base_r <= seg.base;
    end
  end

  // Output register: drop valid on transfer, load when the result is ready
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      temp_centi  <= res_temp;
      below_range <= res_below;
      above_range <= res_above;
      sensor_on   <= sensor_r;
    end
  end

  `TCTT_ASSERT(flags_exclusive, out_valid, !(below_range && above_range), "both range flags set")
  `TCTT_ASSERT(below_clamps, out_valid && below_range, temp_centi == tctt_pkg::TempLow, "below range not clamped")
  `TCTT_ASSERT(above_clamps, out_valid && above_range, temp_centi == tctt_pkg::TempHigh, "above range not clamped")
  `TCTT_ASSERT_NEXT(clamp_skips_walk, in_xfer && clamp, state == tctt_pkg::ST_HOLD, "clamped code entered the walk")

endmodule
